[hw/rtl/mccd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the minimum coin change core.
// No dependencies.
package mccd_pkg;

    localparam int VALUE_W   = 10;
    localparam int VALUE_MAX = (1 << VALUE_W) - 1;
    localparam int COUNT_W   = 3;
    localparam int PICK_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_AMOUNT = 1023;
    localparam int DEF_MAX_COINS  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = 3'd1;

    // one table entry: reach flag, fewest coins, chosen coin index
    typedef struct packed {
        logic               reach;
        logic [VALUE_W-1:0] fewest;
        logic [PICK_W-1:0]  pick;
    } mccd_entry_t;

    // candidate handed to the compare unit
    typedef struct packed {
        logic               take;
        logic               reach;
        logic [VALUE_W-1:0] fewest;
        logic [PICK_W-1:0]  idx;
    } mccd_cand_t;

    // running best from the compare unit
    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] best;
        logic [PICK_W-1:0]  pick;
    } mccd_best_t;

endpackage

[hw/rtl/mccd_if.sv]
`timescale 1ns / 1ps
// Request and result channel interfaces of the coin change core.
// Depends on mccd_pkg.
interface mccd_req_if
    import mccd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] target_amount;

    modport source (output valid, output target_amount, input ready);
    modport sink (input valid, input target_amount, output ready);
endinterface

interface mccd_res_if
    import mccd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] coin_value;
    logic [VALUE_W-1:0] coins_used;
    logic               unreachable;
    logic               last_result;

    modport source (output valid, output coin_value, output coins_used,
                    output unreachable, output last_result, input ready);
    modport sink (input valid, input coin_value, input coins_used,
                  input unreachable, input last_result, output ready);
endinterface

[hw/rtl/mccd_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port table RAM, one write and one registered read per cycle.
// No dependencies.
module mccd_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mccd_cmp_unit.sv]
`timescale 1ns / 1ps
// Shared compare unit: keeps the fewest-coin candidate seen for one amount.
// Depends on mccd_pkg.
module mccd_cmp_unit
    import mccd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  mccd_cand_t cand,
    output mccd_best_t best
);

    logic               found_reg;
    logic [VALUE_W-1:0] best_reg;
    logic [PICK_W-1:0]  pick_reg;
    logic [VALUE_W-1:0] cand_cnt;
    logic               upd;

    // later coin wins a tie
    assign cand_cnt = cand.fewest + VALUE_W'(1);
    assign upd      = cand.take && cand.reach && (!found_reg || cand_cnt <= best_reg);

    always_comb
    begin
        best.found = found_reg | upd;
        best.best  = upd ? cand_cnt : best_reg;
        best.pick  = upd ? cand.idx : pick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            pick_reg  <= '0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            pick_reg  <= '0;
        end
        else
        begin
            found_reg <= best.found;
            best_reg  <= best.best;
            pick_reg  <= best.pick;
        end
    end

endmodule

[hw/rtl/min_coin_change_dp_core.sv]
`timescale 1ns / 1ps
// Top level of the minimum coin change core: sequencer, config, tallies.
// Depends on mccd_pkg, mccd_if, mccd_ram and mccd_cmp_unit.
//
// Usage: write coin_count (index 0) and coin values (indexes 1..6) on the
// cfg port while the core is idle. Each request on req carries a target
// amount; the core answers with one result per coin in use, in coin order,
// last one flagged by last_result. req.ready is high only while idle.
// Per request: a setup step, then for each amount from 1 to the target one
// table read and one compare per coin through the shared compare unit
// (n = coins in use), then a table read and a tally update per coin on the
// traceback path, then n results. The result register lets the next request
// be taken while the final result still waits. A stalled receiver holds the
// result register and the sequencer waits. Reset restores coin_count 1, all
// coin values 1, zero tallies and an idle core; the table needs no clearing
// since entry 0 is rewritten and every entry is filled before it is read.
module min_coin_change_dp_core
    import mccd_pkg::*;
#(
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
    parameter int MAX_COINS  = DEF_MAX_COINS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    mccd_req_if.sink             req,
    mccd_res_if.source           res
);

    localparam int LIM   = (MAX_AMOUNT < VALUE_MAX) ? MAX_AMOUNT : VALUE_MAX;
    localparam int DEPTH = LIM + 1;
    localparam int AMT_W = $clog2(DEPTH);
    localparam int CI_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int ENT_W = $bits(mccd_entry_t);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_INIT     = 6'b000010,
        ST_FILL     = 6'b000100,
        ST_TRACE_RD = 6'b001000,
        ST_TRACE_US = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] coin_count_reg;
    logic [VALUE_W-1:0] coin_value_reg [MAX_COINS];
    logic [VALUE_W-1:0] tally_reg [MAX_COINS];
    logic [VALUE_W-1:0] tally_next [MAX_COINS];
    logic [AMT_W-1:0]   target_reg, target_next;
    logic [AMT_W-1:0]   amt_reg, amt_next;
    logic [AMT_W-1:0]   left_reg, left_next;
    logic [COUNT_W-1:0] coin_idx_reg, coin_idx_next;
    logic [COUNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic               p_valid_reg, p_valid_next;
    logic [PICK_W-1:0]  p_idx_reg, p_idx_next;
    logic               bad_reg, bad_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [VALUE_W-1:0] out_used_reg, out_used_next;
    logic               out_unr_reg, out_unr_next;
    logic               out_last_reg, out_last_next;

    logic [COUNT_W-1:0] n_eff;
    logic [CI_W-1:0]    sel_idx;
    logic [VALUE_W-1:0] coin_sel;
    logic [VALUE_W-1:0] amt_ext;
    logic [VALUE_W-1:0] left_ext;
    logic [VALUE_W-1:0] trace_coin;
    logic [AMT_W-1:0]   sat_target;

    logic               ram_we;
    logic [AMT_W-1:0]   ram_waddr, ram_raddr;
    mccd_entry_t        ram_wdata, ram_rdata;
    logic [ENT_W-1:0]   ram_rbits;

    logic               cmp_clear;
    mccd_cand_t         cmp_cand;
    mccd_best_t         cmp_best;

    mccd_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AMT_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = mccd_entry_t'(ram_rbits);

    mccd_cmp_unit u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cmp_clear),
        .cand  (cmp_cand),
        .best  (cmp_best)
    );

    always_comb
    begin
        if (coin_count_reg == '0)
            n_eff = COUNT_W'(1);
        else if (coin_count_reg > COUNT_W'(MAX_COINS))
            n_eff = COUNT_W'(MAX_COINS);
        else
            n_eff = coin_count_reg;
    end

    assign sel_idx    = (coin_idx_reg < COUNT_W'(MAX_COINS)) ? coin_idx_reg[CI_W-1:0] : '0;
    assign coin_sel   = coin_value_reg[sel_idx];
    assign amt_ext    = VALUE_W'(amt_reg);
    assign left_ext   = VALUE_W'(left_reg);
    assign trace_coin = (ram_rdata.pick < PICK_W'(MAX_COINS))
                        ? coin_value_reg[ram_rdata.pick[CI_W-1:0]] : '0;
    assign sat_target = (req.target_amount > VALUE_W'(LIM))
                        ? AMT_W'(LIM) : req.target_amount[AMT_W-1:0];

    assign cmp_cand.take   = p_valid_reg;
    assign cmp_cand.reach  = ram_rdata.reach;
    assign cmp_cand.fewest = ram_rdata.fewest;
    assign cmp_cand.idx    = p_idx_reg;

    assign req.ready       = (state_reg == ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.coin_value  = out_value_reg;
    assign res.coins_used  = out_used_reg;
    assign res.unreachable = out_unr_reg;
    assign res.last_result = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        amt_next       = amt_reg;
        left_next      = left_reg;
        coin_idx_next  = coin_idx_reg;
        emit_idx_next  = emit_idx_reg;
        p_valid_next   = 1'b0;
        p_idx_next     = p_idx_reg;
        bad_next       = bad_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_used_next  = out_used_reg;
        out_unr_next   = out_unr_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = amt_reg;
        ram_wdata      = '{reach: cmp_best.found, fewest: cmp_best.best, pick: cmp_best.pick};
        ram_raddr      = left_reg;
        cmp_clear      = 1'b0;

        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    target_next = sat_target;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                ram_we        = 1'b1;
                ram_waddr     = '0;
                ram_wdata     = '{reach: 1'b1, fewest: '0, pick: '0};
                cmp_clear     = 1'b1;
                amt_next      = AMT_W'(1);
                left_next     = target_reg;
                coin_idx_next = '0;
                emit_idx_next = '0;
                bad_next      = 1'b0;
                for (int i = 0; i < MAX_COINS; i++)
                    tally_next[i] = '0;
                state_next    = (target_reg == '0) ? ST_TRACE_RD : ST_FILL;
            end
            ST_FILL:
            begin
                if (coin_idx_reg < n_eff)
                begin
                    ram_raddr     = AMT_W'(amt_ext - coin_sel);
                    p_valid_next  = (coin_sel != '0) && (amt_ext >= coin_sel);
                    p_idx_next    = PICK_W'(coin_idx_reg);
                    coin_idx_next = coin_idx_reg + COUNT_W'(1);
                end
                else
                begin
                    ram_we        = 1'b1;
                    cmp_clear     = 1'b1;
                    coin_idx_next = '0;
                    if (amt_reg == target_reg)
                        state_next = ST_TRACE_RD;
                    else
                        amt_next = amt_reg + AMT_W'(1);
                end
            end
            ST_TRACE_RD:
            begin
                ram_raddr  = left_reg;
                state_next = (left_reg == '0) ? ST_EMIT : ST_TRACE_US;
            end
            ST_TRACE_US:
            begin
                if (!ram_rdata.reach)
                begin
                    bad_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (trace_coin == '0 || trace_coin > left_ext)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    left_next = AMT_W'(left_ext - trace_coin);
                    for (int i = 0; i < MAX_COINS; i++)
                    begin
                        if (COUNT_W'(i) < n_eff && coin_value_reg[i] == trace_coin)
                            tally_next[i] = tally_reg[i] + VALUE_W'(1);
                    end
                    state_next = (left_next == '0) ? ST_EMIT : ST_TRACE_RD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = coin_value_reg[emit_idx_reg[CI_W-1:0]];
                    out_used_next  = bad_reg ? '0 : tally_reg[emit_idx_reg[CI_W-1:0]];
                    out_unr_next   = bad_reg;
                    out_last_next  = (emit_idx_reg == n_eff - COUNT_W'(1));
                    emit_idx_next  = emit_idx_reg + COUNT_W'(1);
                    if (out_last_next)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            coin_idx_reg  <= '0;
            emit_idx_reg  <= '0;
            p_valid_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_COINS; i++)
                tally_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            coin_idx_reg  <= coin_idx_next;
            emit_idx_reg  <= emit_idx_next;
            p_valid_reg   <= p_valid_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            tally_reg     <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        amt_reg       <= amt_next;
        left_reg      <= left_next;
        p_idx_reg     <= p_idx_next;
        out_value_reg <= out_value_next;
        out_used_reg  <= out_used_next;
        out_unr_reg   <= out_unr_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= COUNT_W'(1);
            for (int i = 0; i < MAX_COINS; i++)
                coin_value_reg[i] <= VALUE_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_COIN_COUNT)
                coin_count_reg <= cfg_data[COUNT_W-1:0];
            for (int i = 0; i < MAX_COINS; i++)
            begin
                if (cfg_index == CFG_COIN_VALUE_0 + CFG_IDX_W'(i))
                    coin_value_reg[i] <= cfg_data;
            end
        end
    end

endmodule

[tb/mccd_change_checker.sv]
`timescale 1ns / 1ps
// Checker for the minimum coin change core: tracks config writes, predicts
// the per-coin answer for every accepted request and compares results.
// Depends on mccd_pkg and mccd_if.
module mccd_change_checker
    import mccd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    mccd_req_if                  req,
    mccd_res_if                  res,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] coin_value;
        logic [VALUE_W-1:0] coins_used;
        logic               unreachable;
        logic               last_result;
    } change_result_t;

    logic [COUNT_W-1:0] count_cfg;
    logic [VALUE_W-1:0] denom [DEF_MAX_COINS];
    int unsigned        fewest [DEF_MAX_AMOUNT+1];
    bit                 reached [DEF_MAX_AMOUNT+1];
    int unsigned        chosen [DEF_MAX_AMOUNT+1];
    change_result_t     expected_change [$];

    function automatic int unsigned coins_active();
        if (count_cfg == '0)
            return 1;
        if (count_cfg > DEF_MAX_COINS)
            return DEF_MAX_COINS;
        return 32'(count_cfg);
    endfunction

    function automatic void predict_change(input logic [VALUE_W-1:0] amount_in);
        int unsigned    n, target, amt, i, c, cand, best, pick, left;
        bit             found, blocked;
        int unsigned    tally [DEF_MAX_COINS];
        change_result_t r;
        n = coins_active();
        target = 32'(amount_in);
        if (target > DEF_MAX_AMOUNT)
            target = DEF_MAX_AMOUNT;
        fewest[0] = 0;
        reached[0] = 1'b1;
        chosen[0] = 0;
        for (amt = 1; amt <= target; amt++)
        begin
            found = 1'b0;
            best = 0;
            pick = 0;
            for (i = 0; i < n; i++)
            begin
                c = 32'(denom[i]);
                if (c != 0 && amt >= c && reached[amt - c])
                begin
                    cand = fewest[amt - c] + 1;
                    // later coin wins a tie
                    if (!found || cand <= best)
                    begin
                        found = 1'b1;
                        best = cand;
                        pick = i;
                    end
                end
            end
            reached[amt] = found;
            fewest[amt] = found ? best : 0;
            chosen[amt] = pick;
        end
        for (i = 0; i < DEF_MAX_COINS; i++)
            tally[i] = 0;
        blocked = !reached[target];
        if (!blocked)
        begin
            left = target;
            while (left > 0)
            begin
                c = 32'(denom[chosen[left] % DEF_MAX_COINS]);
                if (c == 0 || c > left)
                    break;
                left -= c;
                // every coin sharing the value is counted
                for (i = 0; i < n; i++)
                    if (denom[i] == c)
                        tally[i] = (tally[i] + 1) & VALUE_MAX;
            end
        end
        for (i = 0; i < n; i++)
        begin
            r.coin_value = denom[i];
            r.coins_used = blocked ? '0 : VALUE_W'(tally[i]);
            r.unreachable = blocked;
            r.last_result = (i + 1 == n);
            expected_change.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        change_result_t got, want;
        if (!rst_n)
        begin
            count_cfg = COUNT_W'(1);
            for (int k = 0; k < DEF_MAX_COINS; k++)
                denom[k] = VALUE_W'(1);
            expected_change.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_COIN_COUNT)
                    count_cfg = cfg_data[COUNT_W-1:0];
                else if (cfg_index >= CFG_COIN_VALUE_0
                         && cfg_index < CFG_COIN_VALUE_0 + DEF_MAX_COINS)
                    denom[cfg_index - CFG_COIN_VALUE_0] = cfg_data;
            end
            if (res.valid && res.ready)
            begin
                got = {res.coin_value, res.coins_used, res.unreachable, res.last_result};
                results_seen++;
                if (expected_change.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: value %0d used %0d unreachable %0b last %0b",
                                 got.coin_value, got.coins_used, got.unreachable,
                                 got.last_result);
                end
                else
                begin
                    want = expected_change.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"mismatch at result %0d: expected value %0d used %0d ",
                                      "unreachable %0b last %0b, got value %0d used %0d ",
                                      "unreachable %0b last %0b"},
                                     results_seen, want.coin_value, want.coins_used,
                                     want.unreachable, want.last_result, got.coin_value,
                                     got.coins_used, got.unreachable, got.last_result);
                    end
                end
            end
            if (req.valid && req.ready)
                predict_change(req.target_amount);
            pending = expected_change.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the coin change testbench: clock, reset, config writes, bursty
// requests and a stalling result receiver; verdict from the checker.
// Depends on mccd_pkg, mccd_if, min_coin_change_dp_core and mccd_change_checker.
module tb
    import mccd_pkg::*;
();

    localparam int CYCLE_LIMIT   = 5000000;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int LONG_HOLD     = 3000;
    localparam int RAND_PHASES   = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE =
        CFG_IDX_W'(CFG_COIN_VALUE_0 + DEF_MAX_COINS);

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_STALL} sink_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]   cfg_data;

    mccd_req_if req_ch ();
    mccd_res_if res_ch ();

    int fail_count, pending, results_seen;
    int cycle_count = 0;
    int requests_sent = 0;
    int settings_loaded = 0;
    int burst_left = 0;
    int hold_asks = 0;

    int unsigned        count_setup;
    logic [VALUE_W-1:0] coin_setup [DEF_MAX_COINS];

    min_coin_change_dp_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    mccd_change_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result receiver: open, random and stalled stretches, plus a long hold on request
    initial
    begin
        int         hold_seen;
        int         hold_left;
        int         stall_left;
        sink_mode_t stall_mode;
        hold_seen = 0;
        hold_left = 0;
        stall_left = 0;
        stall_mode = SINK_OPEN;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = sink_mode_t'($urandom_range(0, 2));
                    stall_left = (stall_mode == SINK_STALL) ? $urandom_range(1, 20)
                                                            : $urandom_range(10, 200);
                end
                stall_left--;
                case (stall_mode)
                    SINK_OPEN:   res_ch.ready <= 1'b1;
                    SINK_RANDOM: res_ch.ready <= ($urandom_range(0, 9) < 7);
                    default:     res_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_setting();
        // junk above the count bits is ignored by the core
        write_reg(CFG_COIN_COUNT, VALUE_W'(count_setup & 7)
                  | (VALUE_W'($urandom_range(0, 127)) << COUNT_W));
        for (int k = 0; k < DEF_MAX_COINS; k++)
            write_reg(CFG_IDX_W'(CFG_COIN_VALUE_0 + k), coin_setup[k]);
        write_reg(CFG_SPARE, VALUE_W'($urandom));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic set_coins(input int unsigned count_raw,
                             input int unsigned v0, input int unsigned v1,
                             input int unsigned v2, input int unsigned v3,
                             input int unsigned v4, input int unsigned v5);
        count_setup = count_raw;
        coin_setup[0] = VALUE_W'(v0);
        coin_setup[1] = VALUE_W'(v1);
        coin_setup[2] = VALUE_W'(v2);
        coin_setup[3] = VALUE_W'(v3);
        coin_setup[4] = VALUE_W'(v4);
        coin_setup[5] = VALUE_W'(v5);
        apply_setting();
    endtask

    task automatic offer_target(input int unsigned amount);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.target_amount <= VALUE_W'(amount);
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        requests_sent++;
    endtask

    task automatic end_phase();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int p, k, r, t;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_COIN_COUNT;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.target_amount <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset setting: a single coin of value one
        offer_target(0);
        offer_target(1);
        offer_target(VALUE_MAX);
        end_phase();

        // gaps in the reachable amounts
        set_coins(3, 4, 6, 9, 1, 1, 1);
        offer_target(0);
        offer_target(1);
        offer_target(7);
        offer_target(8);
        offer_target(11);
        offer_target(17);
        offer_target(VALUE_MAX);
        end_phase();

        // count of zero with a zero coin: nothing but zero is reachable
        set_coins(0, 0, 5, 5, 5, 5, 5);
        offer_target(0);
        offer_target(5);
        end_phase();

        set_coins(0, VALUE_MAX, 1, 1, 1, 1, 1);
        offer_target(VALUE_MAX);
        offer_target(VALUE_MAX - 1);
        end_phase();

        // count above range, zero, duplicate and top-value coins
        set_coins(7, 0, 2, 2, VALUE_MAX, 5, 1);
        offer_target(0);
        offer_target(1);
        offer_target(3);
        offer_target(4);
        offer_target(VALUE_MAX);
        offer_target(512);
        offer_target(682);
        offer_target(341);
        end_phase();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            count_setup = $urandom_range(0, 7);
            for (k = 0; k < DEF_MAX_COINS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    coin_setup[k] = '0;
                else if (r < 70)
                    coin_setup[k] = VALUE_W'($urandom_range(1, 12));
                else if (r < 90)
                    coin_setup[k] = VALUE_W'($urandom_range(13, 100));
                else
                    coin_setup[k] = VALUE_W'($urandom_range(101, VALUE_MAX));
            end
            apply_setting();
            if (p == 1)
                hold_asks++;
            k = $urandom_range(8, 16);
            repeat (k)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    t = $urandom_range(0, 63);
                else if (r < 95)
                    t = $urandom_range(64, 300);
                else
                    t = $urandom_range(301, VALUE_MAX);
                offer_target(t);
            end
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d requests, %0d results, %0d coin settings, %0d failures",
                 requests_sent, results_seen, settings_loaded + 1, fail_count);
        $display("incl. zero, duplicate and top-value coins, unreachable targets, long hold-off");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
